/* hdl/smtp_data_dot_unstuffer_top_macros.svh */
// ---------------------------------------------------------------------------
// smtp data dot unstuffer assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef SMTP_DATA_DOT_UNSTUFFER_TOP_MACROS_SVH
`define SMTP_DATA_DOT_UNSTUFFER_TOP_MACROS_SVH

// same-cycle implication
`define SDDU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDDU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sddu_pkg.sv */
// ---------------------------------------------------------------------------
// sddu_pkg
// shared types and codes of the smtp data dot unstuffer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sddu_pkg;

  localparam int unsigned MAX_RES = 3;
  localparam int unsigned CNT_W   = 2;

  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_BEGIN = 1'b1;

  localparam logic KIND_BODY = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic REG_MAX_BYTES = 1'b0;
  localparam logic REG_HOP_LIMIT = 1'b1;

  localparam logic [7:0] HOP_LIMIT_RST = 8'd100;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       last;
    logic [7:0] hop_count;
    logic       too_many_hops;
    logic       size_exceeded;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    out_item_t [MAX_RES-1:0]   item;
  } res_group_t;

  typedef struct packed {
    logic [31:0] max_message_bytes;
    logic [7:0]  hop_limit;
  } cfg_t;

endpackage

/* hdl/smtp_data_dot_unstuffer_top.sv */
// ---------------------------------------------------------------------------
// smtp_data_dot_unstuffer_top
// smtp data phase byte stream cleaner with end report
//
//   channel  direction  payload                      handshake
//   in_      input      sddu_pkg::in_item_t          in_valid / in_ready
//   out_     output     sddu_pkg::out_item_t         out_valid / out_ready
//   cfg_     input      cfg_index, cfg_data          cfg_valid / cfg_ready
//
// a request is registered at the input and processed there in the next cycle;
// its results enter the three-entry result buffer at the edge that takes the
// request, once the buffer is free, and are then offered from the buffer
// the result buffer drains one result per cycle while out_ready is high, so
// sustained rate is one request per cycle at one result each with out_ready
// held high, and requests with no results never wait on the buffer
// synchronous reset leaves the block idle until a begin request
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module smtp_data_dot_unstuffer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sddu_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sddu_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  sddu_pkg::in_item_t    inq_r;
  logic                  inq_valid_r;
  sddu_pkg::cfg_t        cfg_r;
  logic                  take;
  logic                  grp_load;
  logic                  obuf_free;
  sddu_pkg::res_group_t  grp;

  assign in_ready  = !inq_valid_r || take;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      inq_valid_r <= 1'b1;
    end else if (take) begin
      inq_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_message_bytes <= 32'd0;
      cfg_r.hop_limit         <= sddu_pkg::HOP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sddu_pkg::REG_MAX_BYTES: cfg_r.max_message_bytes <= cfg_data;
        sddu_pkg::REG_HOP_LIMIT: cfg_r.hop_limit         <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  sddu_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (inq_valid_r),
    .item       (inq_r),
    .cfg        (cfg_r),
    .obuf_free  (obuf_free),
    .take       (take),
    .grp_load   (grp_load),
    .grp        (grp)
  );

  sddu_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (grp_load),
    .grp       (grp),
    .free      (obuf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hdl/sddu_obuf.sv */
// ---------------------------------------------------------------------------
// sddu_obuf
// result buffer: holds the results of one byte and hands them out in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "smtp_data_dot_unstuffer_top_macros.svh"

module sddu_obuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  sddu_pkg::res_group_t  grp,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sddu_pkg::out_item_t   out_data
);

  sddu_pkg::out_item_t [sddu_pkg::MAX_RES-1:0] res_r;
  logic [sddu_pkg::CNT_W-1:0]                  cnt_r;
  logic                                        pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = res_r[0];
  assign pop       = out_valid && out_ready;
  assign free      = (cnt_r == '0) || ((cnt_r == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= grp.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= grp.item;
    end else if (pop) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  `SDDU_ASSERT_SAME(a_load_when_free, load, free, "result group loaded over pending results")
  `SDDU_ASSERT_NEXT(a_pop_count, pop && !load && cnt_r == 2'd2, cnt_r == 2'd1, "result count slip")
  `SDDU_ASSERT_SAME(a_single_last, cnt_r == 2'd1, res_r[0].last, "final result lacks last")
  `SDDU_ASSERT_SAME(a_pair_last, cnt_r == 2'd2, res_r[1].last && !res_r[0].last, "last misplaced")

endmodule

/* hdl/sddu_core.sv */
// ---------------------------------------------------------------------------
// sddu_core
// message state and single-pass byte processing: lf repair, dot unstuffing,
// terminator detection, header hop counting and size accounting
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sddu_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  sddu_pkg::in_item_t    item,
  input  sddu_pkg::cfg_t        cfg,
  input  logic                  obuf_free,
  output logic                  take,
  output logic                  grp_load,
  output sddu_pkg::res_group_t  grp
);

  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [3:0] HDR_LEN = 4'd9;

  localparam logic [7:0] DLV_LO [9] = '{8'h64, 8'h65, 8'h6c, 8'h69, 8'h76, 8'h65, 8'h72,
                                        8'h65, 8'h64};
  localparam logic [7:0] DLV_UP [9] = '{8'h44, 8'h45, 8'h4c, 8'h49, 8'h56, 8'h45, 8'h52,
                                        8'h45, 8'h44};
  localparam logic [7:0] RCV_LO [8] = '{8'h72, 8'h65, 8'h63, 8'h65, 8'h69, 8'h76, 8'h65,
                                        8'h64};
  localparam logic [7:0] RCV_UP [8] = '{8'h52, 8'h45, 8'h43, 8'h45, 8'h49, 8'h56, 8'h45,
                                        8'h44};

  typedef enum logic [4:0] {
    DS_MID    = 5'b00001,
    DS_LINE   = 5'b00010,
    DS_DOT    = 5'b00100,
    DS_DOT_CR = 5'b01000,
    DS_CR     = 5'b10000
  } dot_state_t;

  typedef struct packed {
    dot_state_t dot;
    logic       seen_cr;
    logic       in_header;
    logic [3:0] header_pos;
    logic       maybe_rcv;
    logic       maybe_dlv;
    logic       maybe_blank;
    logic [7:0] hops;
  } msg_state_t;

  typedef struct packed {
    msg_state_t     st;
    logic [1:0]     nput;
    logic [2:0][7:0] put;
    logic           ended;
  } step_res_t;

  localparam msg_state_t MSG_CLEAR = '{dot: DS_LINE, seen_cr: 1'b0, in_header: 1'b1,
                                       header_pos: 4'd0, maybe_rcv: 1'b1,
                                       maybe_dlv: 1'b1, maybe_blank: 1'b1,
                                       hops: 8'd0};

  function automatic logic [7:0] hop_inc(input logic [7:0] h);
    return (h != 8'hff) ? h + 8'd1 : h;
  endfunction

  function automatic step_res_t char_step(input msg_state_t s, input logic [7:0] c);
    step_res_t  r;
    logic [3:0] p;
    r.st    = s;
    r.nput  = 2'd0;
    r.put   = '0;
    r.ended = 1'b0;
    p       = s.header_pos;
    r.st.seen_cr = (c == CH_CR);
    // header line matching
    if (s.in_header) begin
      if (p < HDR_LEN) begin
        if (c != DLV_LO[p] && c != DLV_UP[p]) r.st.maybe_dlv = 1'b0;
        if (r.st.maybe_dlv && p == 4'd8) r.st.hops = hop_inc(r.st.hops);
        if (p < 4'd8) begin
          if (c != RCV_LO[p[2:0]] && c != RCV_UP[p[2:0]]) r.st.maybe_rcv = 1'b0;
          if (r.st.maybe_rcv && p == 4'd7) r.st.hops = hop_inc(r.st.hops);
        end
        if (p < 4'd2) begin
          if (c != ((p == 4'd0) ? CH_CR : CH_LF)) r.st.maybe_blank = 1'b0;
        end
        if (r.st.maybe_blank && p == 4'd1) r.st.in_header = 1'b0;
        r.st.header_pos = p + 4'd1;
      end
      if (c == CH_LF) begin
        r.st.header_pos  = 4'd0;
        r.st.maybe_rcv   = 1'b1;
        r.st.maybe_dlv   = 1'b1;
        r.st.maybe_blank = 1'b1;
      end
    end
    // dot unstuffing
    case (s.dot)
      DS_LINE: begin
        if (c == CH_DOT) begin
          r.st.dot = DS_DOT;
        end else if (c == CH_CR) begin
          r.st.dot = DS_CR;
        end else begin
          r.st.dot = DS_MID;
          r.put[0] = c;
          r.nput   = 2'd1;
        end
      end
      DS_DOT: begin
        if (c == CH_CR) begin
          r.st.dot = DS_DOT_CR;
        end else begin
          r.st.dot = DS_MID;
          r.put[0] = c;
          r.nput   = 2'd1;
        end
      end
      DS_DOT_CR: begin
        if (c == CH_LF) begin
          r.ended = 1'b1;
        end else begin
          r.put[0] = CH_DOT;
          r.put[1] = CH_CR;
          if (c == CH_CR) begin
            r.st.dot = DS_CR;
            r.nput   = 2'd2;
          end else begin
            r.st.dot = DS_MID;
            r.put[2] = c;
            r.nput   = 2'd3;
          end
        end
      end
      DS_CR: begin
        if (c == CH_LF) begin
          r.st.dot = DS_LINE;
          r.put[0] = c;
          r.nput   = 2'd1;
        end else if (c != CH_CR) begin
          r.st.dot = DS_MID;
          r.put[0] = CH_CR;
          r.put[1] = c;
          r.nput   = 2'd2;
        end else begin
          r.put[0] = c;
          r.nput   = 2'd1;
        end
      end
      default: begin
        if (c == CH_CR) begin
          r.st.dot = DS_CR;
        end else begin
          r.st.dot = DS_MID;
          r.put[0] = c;
          r.nput   = 2'd1;
        end
      end
    endcase
    return r;
  endfunction

  msg_state_t  st_r, st_nxt;
  logic [32:0] bytes_left_r, bytes_left_nxt;
  logic        finished_r, finished_nxt;

  step_res_t   r1, r2;
  logic        bare, use2, ended, is_byte, report;
  msg_state_t  st_after;
  logic [1:0]  n2, nbody;
  logic [2:0]  nsum;
  logic [32:0] bl_after;
  logic [2:0][7:0] body;

  always_comb begin
    is_byte  = (item.func == sddu_pkg::FUNC_BYTE) && !finished_r;
    // a bare lf is handled as cr then lf
    bare     = (item.in_byte == CH_LF) && !st_r.seen_cr;
    r1       = char_step(st_r, bare ? CH_CR : item.in_byte);
    r2       = char_step(r1.st, CH_LF);
    use2     = bare && !r1.ended;
    st_after = use2 ? r2.st : r1.st;
    n2       = use2 ? r2.nput : 2'd0;
    ended    = r1.ended || (use2 && r2.ended);
    nsum     = {1'b0, r1.nput} + {1'b0, n2};
    nbody    = (nsum > 3'd3) ? 2'd3 : nsum[1:0];
    bl_after = ({30'd0, nsum} >= bytes_left_r) ? 33'd0 : bytes_left_r - {30'd0, nsum};

    for (int k = 0; k < 3; k++) begin
      if (2'(k) < r1.nput) body[k] = r1.put[k];
      else                 body[k] = r2.put[2'(k) - r1.nput];
    end

    grp = '0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < nbody) begin
        grp.item[k].kind     = sddu_pkg::KIND_BODY;
        grp.item[k].out_byte = body[k];
      end
    end
    report  = ended && (nbody != 2'd3);
    grp.cnt = nbody;
    if (report) begin
      grp.item[nbody].kind          = sddu_pkg::KIND_END;
      grp.item[nbody].hop_count     = st_after.hops;
      grp.item[nbody].too_many_hops = (st_after.hops >= cfg.hop_limit);
      grp.item[nbody].size_exceeded = (cfg.max_message_bytes != 32'd0) && (bl_after == 33'd0);
      grp.cnt = nbody + 2'd1;
    end
    if (!is_byte) grp.cnt = 2'd0;
    if (grp.cnt != 2'd0) grp.item[grp.cnt - 2'd1].last = 1'b1;

    take     = item_valid && ((grp.cnt == 2'd0) || obuf_free);
    grp_load = take && (grp.cnt != 2'd0);

    st_nxt         = st_r;
    bytes_left_nxt = bytes_left_r;
    finished_nxt   = finished_r;
    if (item.func == sddu_pkg::FUNC_BEGIN) begin
      st_nxt         = MSG_CLEAR;
      bytes_left_nxt = (cfg.max_message_bytes != 32'd0) ?
                       {1'b0, cfg.max_message_bytes} + 33'd1 : 33'd0;
      finished_nxt   = 1'b0;
    end else if (is_byte) begin
      st_nxt         = st_after;
      bytes_left_nxt = bl_after;
      finished_nxt   = report;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= MSG_CLEAR;
      bytes_left_r <= 33'd0;
      finished_r   <= 1'b1;
    end else if (take) begin
      st_r         <= st_nxt;
      bytes_left_r <= bytes_left_nxt;
      finished_r   <= finished_nxt;
    end
  end

endmodule
